FILE: rtl/core/fpcs_pkg.sv
// Package for the five-point cross smoother.
// Field widths, register indexes, payload types and divide-by-five constants.
// No dependencies.
package fpcs_pkg;

    // Field widths
    localparam int PIX_W     = 16;
    localparam int ROW_W     = 12;
    localparam int COL_W     = 11;
    localparam int WCFG_W    = 12;
    localparam int HCFG_W    = 13;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    // Sizes and reset values
    localparam int                MAX_WIDTH_DEF = 2048;
    localparam int                MAX_HEIGHT    = 4096;
    localparam logic [WCFG_W-1:0] WIDTH_RESET   = 12'd2048;
    localparam logic [HCFG_W-1:0] HEIGHT_RESET  = 13'd2048;

    // Five-sample sum and its division by five: q = (s * M) >> S, exact for s < 5 * 2^17
    localparam int                   SUM_W      = PIX_W + 3;
    localparam int                   DIV5_MUL_W = 19;
    localparam int                   DIV5_SHIFT = 21;
    localparam logic [DIV5_MUL_W-1:0] DIV5_MUL  = 19'd419431;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic             frame_start;
    } t_pix_in;

    typedef struct packed {
        logic [PIX_W-1:0] smoothed_value;
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_col;
        logic             frame_done;
    } t_res_out;

endpackage

FILE: rtl/core/fpcs_stream_if.sv
// Valid/ready stream channel carrying one request per handshake.
// Payload type is a parameter; used with the types of fpcs_pkg.
interface fpcs_stream_if #(
    parameter type T_PAYLOAD = logic
);
    logic     valid;
    logic     ready;
    T_PAYLOAD payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/fpcs_line_store.sv
// One line store: single write port, single read port, registered read data.
// Depends on nothing but its parameters; contents undefined until written.
module fpcs_line_store #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/five_point_cross_smoother.sv
// Five-point cross smoother: top level.
// Uses fpcs_pkg, fpcs_stream_if and two fpcs_line_store instances.
//
// Usage:
//   i_pix takes one pixel request per cycle in raster order unless o_res
//   stalls; frame_start places that pixel at row 0, column 0. o_res gives
//   one request for each interior pixel (not first/last row or column): the
//   truncated mean of the pixel and its four neighbours, with its row, column
//   and a frame_done flag on the last interior pixel of the frame. The result
//   for (r-1, c) follows the pixel at (r, c): line store read into stage 1,
//   sum into stage 2, then divide into the output register. Throughput is one
//   pixel per cycle unless o_res stalls, set by the single read and single
//   write port of each line store used once per pixel; a write in flight is
//   forwarded to a read of the same entry in the same cycle.
//   Configuration (i_cfg_we/i_cfg_idx/i_cfg_data) sets image width and
//   height; write it only while no pixel is in flight.
//   Reset clears the position, the window registers and the pipeline; the
//   line stores are not cleared and need no clearing pass. When o_res is
//   stalled the pipeline fills and i_pix.ready falls; nothing is dropped.
module five_point_cross_smoother #(
    parameter int MAX_WIDTH = fpcs_pkg::MAX_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    fpcs_stream_if.sink                     i_pix,
    fpcs_stream_if.source                   o_res,
    input  logic                            i_cfg_we,
    input  logic [fpcs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fpcs_pkg::CFG_W-1:0]      i_cfg_data
);

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int WC_W  = (fpcs_pkg::WCFG_W > $clog2(MAX_WIDTH + 1)) ?
                           fpcs_pkg::WCFG_W : $clog2(MAX_WIDTH + 1);
    localparam int PIX_W = fpcs_pkg::PIX_W;
    localparam int SUM_W = fpcs_pkg::SUM_W;
    localparam int ROW_W = fpcs_pkg::ROW_W;
    localparam int HC_W  = fpcs_pkg::HCFG_W;
    localparam int PRD_W = SUM_W + fpcs_pkg::DIV5_MUL_W;

    // Configuration registers
    logic [fpcs_pkg::WCFG_W-1:0] r_image_width;
    logic [HC_W-1:0]             r_image_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= fpcs_pkg::WIDTH_RESET;
            r_image_height <= fpcs_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fpcs_pkg::REG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg_data[fpcs_pkg::WCFG_W-1:0];
                end
                fpcs_pkg::REG_IMAGE_HEIGHT: begin
                    r_image_height <= i_cfg_data[HC_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Clamped frame size, as last index and last interior index
    logic [WC_W-1:0]  w_raw, w_eff;
    logic [HC_W-1:0]  h_eff;
    logic [AW-1:0]    w_last, w_last2;
    logic [ROW_W-1:0] h_last, h_last2;

    always_comb begin
        w_raw = WC_W'(r_image_width);
        if (w_raw < WC_W'(3)) begin
            w_eff = WC_W'(3);
        end else if (w_raw > WC_W'(MAX_WIDTH)) begin
            w_eff = WC_W'(MAX_WIDTH);
        end else begin
            w_eff = w_raw;
        end
        if (r_image_height < HC_W'(3)) begin
            h_eff = HC_W'(3);
        end else if (r_image_height > HC_W'(fpcs_pkg::MAX_HEIGHT)) begin
            h_eff = HC_W'(fpcs_pkg::MAX_HEIGHT);
        end else begin
            h_eff = r_image_height;
        end
        w_last  = AW'(w_eff - WC_W'(1));
        w_last2 = AW'(w_eff - WC_W'(2));
        h_last  = ROW_W'(h_eff - HC_W'(1));
        h_last2 = ROW_W'(h_eff - HC_W'(2));
    end

    // Pipeline handshake
    logic r_v1, r_res1, r_v2, r_ov;
    logic o_free, s2_free, s1_go, acc;

    assign o_free      = !r_ov || o_res.ready;
    assign s2_free     = !r_v2 || o_free;
    assign s1_go       = r_v1 && (!r_res1 || s2_free);
    assign i_pix.ready = !r_v1 || s1_go;
    assign acc         = i_pix.valid && i_pix.ready;

    // Stage 0: position, result decision, line store read addresses
    logic [AW-1:0]    r_col, n_col, c0, ma0;
    logic [ROW_W-1:0] r_row, n_row, r0;
    logic             res0, done0, rz0, hit_u0, hit_m0;
    logic [AW-1:0]    r_c1;

    always_comb begin
        c0    = i_pix.payload.frame_start ? '0 : r_col;
        r0    = i_pix.payload.frame_start ? '0 : r_row;
        res0  = (r0 >= ROW_W'(2)) && (r0 <= h_last) && (c0 != '0) && (c0 <= w_last2);
        done0 = (r0 == h_last) && (c0 == w_last2);
        rz0   = (c0 == AW'(MAX_WIDTH - 1));
        ma0   = rz0 ? '0 : AW'(c0 + 1'b1);
        if (c0 >= w_last) begin
            n_col = '0;
            n_row = (r0 >= h_last) ? '0 : ROW_W'(r0 + 1'b1);
        end else begin
            n_col = AW'(c0 + 1'b1);
            n_row = r0;
        end
        // the write of the item leaving stage 1 lands in this same cycle
        hit_u0 = s1_go && (r_c1 == c0);
        hit_m0 = s1_go && !rz0 && (r_c1 == ma0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Stage 1 registers
    logic [PIX_W-1:0] r_pix1, r_fwd_u1, r_fwd_m1;
    logic [ROW_W-1:0] r_row1;
    logic             r_done1, r_first1, r_rz1, r_hit_u1, r_hit_m1;

    // Middle-row window and shadow of middle store entry 0
    logic [PIX_W-1:0] r_mc, r_ml, r_m0;
    logic [PIX_W-1:0] mc_eff, ml_eff, above, right;
    logic [PIX_W-1:0] u_rdata, m_rdata;
    logic [SUM_W-1:0] sum1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (acc) begin
            r_v1 <= 1'b1;
        end else if (s1_go) begin
            r_v1 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_pix1   <= i_pix.payload.pixel_value;
            r_c1     <= c0;
            r_row1   <= ROW_W'(r0 - 1'b1);
            r_res1   <= res0;
            r_done1  <= done0;
            r_first1 <= (c0 == '0);
            r_rz1    <= rz0;
            r_hit_u1 <= hit_u0;
            r_hit_m1 <= hit_m0;
            r_fwd_u1 <= mc_eff;
            r_fwd_m1 <= r_pix1;
        end
    end

    // Stage 1: assemble the cross and sum it
    always_comb begin
        mc_eff = r_first1 ? r_m0 : r_mc;
        ml_eff = r_first1 ? '0 : r_ml;
        above  = r_hit_u1 ? r_fwd_u1 : u_rdata;
        right  = r_rz1 ? '0 : (r_hit_m1 ? r_fwd_m1 : m_rdata);
        sum1   = SUM_W'(mc_eff) + SUM_W'(ml_eff) + SUM_W'(right)
               + SUM_W'(above) + SUM_W'(r_pix1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mc <= '0;
            r_ml <= '0;
            r_m0 <= '0;
        end else if (s1_go) begin
            r_ml <= mc_eff;
            r_mc <= right;
            if (r_c1 == '0) begin
                r_m0 <= r_pix1;
            end
        end
    end

    // Line stores: upper row takes the old middle row, middle row takes the pixel
    fpcs_line_store #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (PIX_W),
        .AW    (AW)
    ) u_upper (
        .i_clk   (i_clk),
        .i_we    (s1_go),
        .i_waddr (r_c1),
        .i_wdata (mc_eff),
        .i_re    (acc),
        .i_raddr (c0),
        .o_rdata (u_rdata)
    );

    fpcs_line_store #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (PIX_W),
        .AW    (AW)
    ) u_middle (
        .i_clk   (i_clk),
        .i_we    (s1_go),
        .i_waddr (r_c1),
        .i_wdata (r_pix1),
        .i_re    (acc),
        .i_raddr (ma0),
        .o_rdata (m_rdata)
    );

    // Stage 2: sum registered, divide by five via reciprocal multiply
    logic [SUM_W-1:0]          r_sum2;
    logic [ROW_W-1:0]          r_row2;
    logic [fpcs_pkg::COL_W-1:0] r_col2;
    logic                      r_done2;
    logic [PRD_W-1:0]          prod2;
    fpcs_pkg::t_res_out        r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (s2_free) begin
            r_v2 <= s1_go && r_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free) begin
            r_sum2  <= sum1;
            r_row2  <= r_row1;
            r_col2  <= fpcs_pkg::COL_W'(r_c1);
            r_done2 <= r_done1;
        end
    end

    assign prod2 = PRD_W'(r_sum2) * PRD_W'(fpcs_pkg::DIV5_MUL);

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (o_free) begin
            r_ov <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free) begin
            r_out.smoothed_value <= prod2[fpcs_pkg::DIV5_SHIFT +: PIX_W];
            r_out.out_row        <= r_row2;
            r_out.out_col        <= r_col2;
            r_out.frame_done     <= r_done2;
        end
    end

    assign o_res.valid   = r_ov;
    assign o_res.payload = r_out;

    // Checks
    a_col_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> (r_col == '0) || (r_col == AW'($past(c0) + 1'b1)))
        else $error("column counter neither advanced nor wrapped");

    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.payload.out_row != '0) && (o_res.payload.out_col != '0))
        else $error("result given for a border pixel");

    a_fwd_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && s1_go && (r_c1 == c0)) |=> r_hit_u1)
        else $error("upper store write not forwarded to same-entry read");

    a_done_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_done2) |-> (r_row2 == h_last2))
        else $error("frame_done away from last interior row");

endmodule
